/* design/gfp_pkg.sv */
// Package for the grayscale frame packer: sizes, operation codes and the
// command type passed from the front end to the back end.
// Depends on nothing.
package gfp_pkg;

	localparam int CHIP_COUNT    = 1;
	localparam int CHANNEL_COUNT = 16 * CHIP_COUNT;
	localparam int ROW_COUNT     = 8 * CHIP_COUNT;
	localparam int FRAME_BYTES   = 24 * CHIP_COUNT;
	localparam int CH_W          = $clog2(CHANNEL_COUNT);
	localparam int ROW_W         = $clog2(ROW_COUNT);
	localparam int ROW_BITS      = 24;
	localparam int GRAY_W        = 12;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = $clog2(QDEPTH);

	localparam logic [1:0] OP_WRITE_ONE = 2'd0;
	localparam logic [1:0] OP_WRITE_ALL = 2'd1;
	localparam logic [1:0] OP_SEND      = 2'd2;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_SEND  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ROW_W-1:0]   row;
		logic               odd;
		logic [GRAY_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

/* design/gfp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module gfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/gfp_front.sv */
// Front end of the grayscale frame packer: takes requests, decodes them into
// commands and holds them in a two-entry queue for the back end.
// Depends on gfp_pkg.
module gfp_front
	import gfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        op,
	input  logic [4:0]        channel,
	input  logic [GRAY_W-1:0] gray_value,
	output cmd_req_t          cmd_req,
	input  logic              cmd_take
);

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	cmd_t              dec_cmd;
	logic              dec_keep;
	logic              in_range;
	logic [CH_W-1:0]   rev_ch;
	logic              enq;
	logic              deq;

	assign in_range = ({1'b0, channel} < 6'(CHANNEL_COUNT));
	assign rev_ch   = CH_W'(CHANNEL_COUNT - 1) - channel[CH_W-1:0];

	always_comb begin
		dec_cmd.kind  = CMD_WRITE;
		dec_cmd.row   = rev_ch[CH_W-1:1];
		dec_cmd.odd   = rev_ch[0];
		dec_cmd.value = gray_value;
		dec_keep      = 1'b0;
		case (op)
			OP_WRITE_ONE: begin
				dec_keep = in_range;
			end
			OP_WRITE_ALL: begin
				dec_cmd.kind = CMD_FILL;
				dec_keep     = 1'b1;
			end
			OP_SEND: begin
				dec_cmd.kind = CMD_SEND;
				dec_keep     = 1'b1;
			end
			default: begin
				dec_keep = 1'b0;
			end
		endcase
	end

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign enq   = push && !full && dec_keep;
	assign deq   = cmd_take && (count_q != '0);

	assign cmd_req.valid = (count_q != '0);
	assign cmd_req.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem_q[wr_ptr_q] <= dec_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/gfp_back.sv */
// Back end of the grayscale frame packer: owns the packed frame store and
// carries out channel writes, frame fills and frame sends.
// Depends on gfp_pkg and gfp_ram.
module gfp_back
	import gfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_req_t   cmd_req,
	output logic       cmd_take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_RMW       = 4'b0010,
		ST_SEND_LOAD = 4'b0100,
		ST_SEND_BYTE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [ROW_COUNT-1:0]  valid_q;
	logic [GRAY_W-1:0]     fill_q;
	logic [ROW_W-1:0]      row_cnt_q;
	logic [1:0]            byte_idx_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic [ROW_BITS-1:0]   row_buf_q;
	cmd_t                  cmd_q;

	logic                  ram_we;
	logic                  ram_re;
	logic [ROW_W-1:0]      ram_raddr;
	logic [ROW_BITS-1:0]   ram_rdata;
	logic [ROW_BITS-1:0]   ram_wdata;
	logic [ROW_W-1:0]      sel_row;
	logic [ROW_W-1:0]      next_row;
	logic [ROW_BITS-1:0]   row_data;
	logic                  last_row;
	logic                  out_load;
	logic [7:0]            cur_byte;

	gfp_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROW_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd_q.row),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign next_row = row_cnt_q + 1'b1;
	assign last_row = (row_cnt_q == ROW_W'(ROW_COUNT - 1));
	assign cmd_take = (state_q == ST_IDLE) && cmd_req.valid;
	assign out_load = (state_q == ST_SEND_BYTE) && (!out_valid_q || pop);

	always_comb begin
		case (state_q)
			ST_RMW:       sel_row = cmd_q.row;
			ST_SEND_LOAD: sel_row = row_cnt_q;
			default:      sel_row = next_row;
		endcase
	end

	// A row never written since reset or the last fill reads as the fill pattern.
	assign row_data = valid_q[sel_row] ? ram_rdata : {fill_q, fill_q};

	assign ram_wdata = cmd_q.odd ? {row_data[23:12], cmd_q.value}
	                             : {cmd_q.value, row_data[11:0]};
	assign ram_we    = (state_q == ST_RMW);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cmd_req.cmd.row;
		if (cmd_take && (cmd_req.cmd.kind == CMD_WRITE)) begin
			ram_re = 1'b1;
		end else if (cmd_take && (cmd_req.cmd.kind == CMD_SEND)) begin
			ram_re    = 1'b1;
			ram_raddr = '0;
		end else if (out_load && (byte_idx_q == 2'd1) && !last_row) begin
			ram_re    = 1'b1;
			ram_raddr = next_row;
		end
	end

	always_comb begin
		case (byte_idx_q)
			2'd0:    cur_byte = row_buf_q[23:16];
			2'd1:    cur_byte = row_buf_q[15:8];
			default: cur_byte = row_buf_q[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			fill_q      <= '0;
			row_cnt_q   <= '0;
			byte_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						case (cmd_req.cmd.kind)
							CMD_FILL: begin
								fill_q  <= cmd_req.cmd.value;
								valid_q <= '0;
							end
							CMD_WRITE: begin
								state_q <= ST_RMW;
							end
							CMD_SEND: begin
								row_cnt_q <= '0;
								state_q   <= ST_SEND_LOAD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RMW: begin
					valid_q[cmd_q.row] <= 1'b1;
					state_q            <= ST_IDLE;
				end
				ST_SEND_LOAD: begin
					byte_idx_q <= '0;
					state_q    <= ST_SEND_BYTE;
				end
				ST_SEND_BYTE: begin
					if (out_load) begin
						if (byte_idx_q == 2'd2) begin
							byte_idx_q <= '0;
							if (last_row) begin
								state_q <= ST_IDLE;
							end else begin
								row_cnt_q <= next_row;
							end
						end else begin
							byte_idx_q <= byte_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd_req.cmd;
		end
		if ((state_q == ST_SEND_LOAD) ||
		    (out_load && (byte_idx_q == 2'd2) && !last_row)) begin
			row_buf_q <= row_data;
		end
		if (out_load) begin
			out_byte_q <= cur_byte;
			out_last_q <= last_row && (byte_idx_q == 2'd2);
		end
	end

	assign empty      = !out_valid_q;
	assign frame_byte = out_byte_q;
	assign last_byte  = out_last_q;

	a_send_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && (cmd_req.cmd.kind == CMD_SEND)) |=> (state_q == ST_SEND_LOAD))
		else $error("Frame send did not start with a row load.");

	a_byte_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND_BYTE) |-> (byte_idx_q != 2'd3))
		else $error("Byte index left the three bytes of a row.");

	a_send_ends_marked: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEND_BYTE) ##1 (state_q == ST_IDLE)) |-> (out_last_q && out_valid_q))
		else $error("Frame send ended without a marked last byte.");

	a_no_write_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEND_LOAD) || (state_q == ST_SEND_BYTE)) |-> !ram_we)
		else $error("Frame store written during a send.");

endmodule

/* design/grayscale_frame_packer_unit.sv */
// Top level of the grayscale frame packer.
// Depends on gfp_pkg, gfp_front and gfp_back.
//
// The block keeps a packed frame of 12-bit grayscale values, 16 channels per
// chip, two channels to three bytes with the highest channel first.
// Requests enter through push/full: op 0 writes one channel, op 1 writes all
// channels, op 2 sends the frame; other ops and out-of-range channels are
// dropped. A decoded request waits in a two-entry queue for the back end.
// Bytes leave through empty/pop, each with last_byte set on the final one.
// A channel write reads its row when the back end takes it, then merges and
// writes the three-byte row in the store RAM; a full write only sets the
// fill value and clears the row valid bits. A send reads row 0 into a row
// buffer and then streams 24 bytes per chip at one byte per cycle while the
// receiver pops, with one single-port read of a row every three bytes.
// When the receiver stalls, the output register holds its byte and the back
// end waits; the queue keeps accepting requests until it holds two.
// Reset clears the frame to zero at once through per-row valid bits and a
// zero fill value, so the block accepts requests as soon as reset is released.
module grayscale_frame_packer_unit
	import gfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        op,
	input  logic [4:0]        channel,
	input  logic [GRAY_W-1:0] gray_value,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        frame_byte,
	output logic              last_byte
);

	cmd_req_t cmd_req;
	logic     cmd_take;

	gfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.channel    (channel),
		.gray_value (gray_value),
		.cmd_req    (cmd_req),
		.cmd_take   (cmd_take)
	);

	gfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_req    (cmd_req),
		.cmd_take   (cmd_take),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
